>>> design/fqs_pkg.sv
// Package for the FIFO queue with membership search.
// Holds the depth, widths, opcode/status codes, cell commands and result layout.
// No dependencies.
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int OUT_W  = 2 + 1 + DATA_W + DATA_W + CNT_W + 1;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2,
    OP_NOP  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_mode_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_SEARCH
  } fsm_t;

  typedef struct packed {
    cell_mode_t          mode;
    logic [DATA_W-1:0]   load_data;
  } cell_cmd_t;

  // packed with status in the lowest bits
  typedef struct packed {
    logic                is_empty;
    logic [CNT_W-1:0]    entry_count;
    logic [DATA_W-1:0]   back_value;
    logic [DATA_W-1:0]   front_value;
    logic                found;
    status_t             status;
  } result_t;

endpackage

>>> design/fifo_queue_with_search_core.sv
// Top level of the FIFO queue with membership search: controller plus a row of entry cells.
// Depends on fqs_pkg, fqs_cell and fqs_ctrl.
//
//   channel | ports                      | carries
//   in      | in_tvalid/tready/tdata/tuser | opcode (tuser), value (tdata)
//   out     | out_tvalid/tready/tdata    | status, found, front, back, count, empty
//
// Enqueue, dequeue, no-op and a search of an empty queue are answered directly. A search of
// a non-empty queue rotates the cell chain once per held entry in the SEARCH state, past
// the compare at the front cell; in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the queue; cell contents are not cleared.
// A result waits in the output register; the next transaction is taken as it drains.
`timescale 1ns / 1ps

module fifo_queue_with_search_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fqs_pkg::DATA_W-1:0]       in_tdata,   // value
  input  logic [1:0]                       in_tuser,   // opcode
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status, found, front_value, back_value, entry_count, is_empty
  output logic [fqs_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import fqs_pkg::*;

  cell_cmd_t         cmd;
  result_t           res;
  logic [CNT_W-1:0]  count;
  logic [DATA_W-1:0] cell_data [DEPTH];

  fqs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res_o  (res),
    .head_i     (cell_data[0]),
    .second_i   (cell_data[1]),
    .cmd_o      (cmd),
    .count_o    (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] nbr;
    if (i < DEPTH - 1) begin : g_mid
      assign nbr = cell_data[i+1];
    end else begin : g_end
      assign nbr = cell_data[0];
    end
    fqs_cell u_cell (
      .clk      (clk),
      .cmd_i    (cmd),
      .wr_sel_i (count == CNT_W'(i)),
      .last_i   (count == CNT_W'(i + 1)),
      .nbr_i    (nbr),
      .head_i   (cell_data[0]),
      .data_o   (cell_data[i])
    );
  end

  assign out_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, res};

endmodule

>>> design/fqs_cell.sv
// One queue cell: holds one entry; on shift or rotate takes its neighbor's or the head's.
// Depends on fqs_pkg.
`timescale 1ns / 1ps

module fqs_cell (
  input  logic                      clk,
  input  fqs_pkg::cell_cmd_t        cmd_i,
  input  logic                      wr_sel_i,
  input  logic                      last_i,
  input  logic [fqs_pkg::DATA_W-1:0] nbr_i,
  input  logic [fqs_pkg::DATA_W-1:0] head_i,
  output logic [fqs_pkg::DATA_W-1:0] data_o
);
  import fqs_pkg::*;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    case (cmd_i.mode)
      CELL_LOAD:   data_nxt = wr_sel_i ? cmd_i.load_data : data_r;
      CELL_SHIFT:  data_nxt = nbr_i;
      CELL_ROTATE: data_nxt = last_i ? head_i : nbr_i;
      default:     data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

>>> design/fqs_ctrl.sv
// Queue controller: occupancy, back entry, search sequencer and output register.
// Drives the cell chain commands. Depends on fqs_pkg.
`timescale 1ns / 1ps

module fqs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fqs_pkg::DATA_W-1:0]    in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output fqs_pkg::result_t              out_res_o,
  input  logic [fqs_pkg::DATA_W-1:0]    head_i,
  input  logic [fqs_pkg::DATA_W-1:0]    second_i,
  output fqs_pkg::cell_cmd_t            cmd_o,
  output logic [fqs_pkg::CNT_W-1:0]     count_o
);
  import fqs_pkg::*;

  fsm_t              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              hit_r, hit_nxt;
  logic [DATA_W-1:0] back_r, back_nxt;
  logic [DATA_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] snap_r, snap_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  logic              out_free;
  logic              accept;
  logic              match;
  opcode_t           op;

  function automatic result_t make_res(status_t st, logic fnd, logic [DATA_W-1:0] fr,
                                       logic [DATA_W-1:0] bk, logic [CNT_W-1:0] cnt);
    result_t r;
    r.status      = st;
    r.found       = fnd;
    r.entry_count = cnt;
    r.is_empty    = (cnt == '0);
    r.front_value = (cnt == '0) ? '0 : fr;
    r.back_value  = (cnt == '0) ? '0 : bk;
    return r;
  endfunction

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == FSM_IDLE) && out_free;
  assign accept    = in_tvalid && in_tready;
  assign match     = (head_i == key_r);
  assign op        = opcode_t'(in_tuser);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    hit_nxt       = hit_r;
    back_nxt      = back_r;
    key_nxt       = key_r;
    snap_nxt      = snap_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    cmd_o.mode      = CELL_HOLD;
    cmd_o.load_data = in_tdata;
    case (state_r)
      FSM_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (op)
            OP_ENQ: begin
              if (count_r == CNT_W'(DEPTH)) begin
                out_res_nxt = make_res(STAT_FULL, 1'b0, head_i, back_r, count_r);
              end else begin
                cmd_o.mode  = CELL_LOAD;
                count_nxt   = count_r + CNT_W'(1);
                back_nxt    = in_tdata;
                out_res_nxt = make_res(STAT_OK, 1'b0,
                                       (count_r == '0) ? in_tdata : head_i,
                                       in_tdata, count_nxt);
              end
            end
            OP_DEQ: begin
              if (count_r == '0) begin
                out_res_nxt = make_res(STAT_EMPTY, 1'b0, '0, '0, count_r);
              end else begin
                cmd_o.mode  = CELL_SHIFT;
                count_nxt   = count_r - CNT_W'(1);
                out_res_nxt = make_res(STAT_OK, 1'b0, second_i, back_r, count_nxt);
              end
            end
            OP_SRCH: begin
              if (count_r == '0) begin
                out_res_nxt = make_res(STAT_OK, 1'b0, '0, '0, count_r);
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = FSM_SEARCH;
                key_nxt       = in_tdata;
                snap_nxt      = head_i;
                k_nxt         = '0;
                hit_nxt       = 1'b0;
              end
            end
            default: begin
              out_res_nxt = make_res(STAT_OK, 1'b0, head_i, back_r, count_r);
            end
          endcase
        end
      end
      FSM_SEARCH: begin
        cmd_o.mode = CELL_ROTATE;
        hit_nxt    = hit_r || match;
        k_nxt      = k_r + CNT_W'(1);
        if (k_r == count_r - CNT_W'(1)) begin
          state_nxt     = FSM_IDLE;
          out_valid_nxt = 1'b1;
          out_res_nxt   = make_res(STAT_OK, hit_r || match, snap_r, back_r, count_r);
        end
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      k_r         <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    back_r    <= back_nxt;
    key_r     <= key_nxt;
    snap_r    <= snap_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_res_o  = out_res_r;
  assign count_o    = count_r;

endmodule
